>>> src/wam_pkg.sv
// ============================================================================
// wam_pkg - shared definitions for the window average energy meter
// Register codes, field widths and the controller/datapath link types.
// ============================================================================
`default_nettype none

package wam_pkg;

   // Default build parameters
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int MAX_WINDOW_DEF  = 1024;

   // Fixed field widths
   localparam int WL_W        = 11;
   localparam int GAIN_W      = 32;
   localparam int WTIME_W     = 24;
   localparam int LIMIT_W     = 47;
   localparam int DELAY_W     = 32;
   localparam int MS_W        = 32;
   localparam int VALUE_W     = 32;
   localparam int ACC_W       = 64;
   localparam int ELAPSED_W   = 48;
   localparam int CSR_DATA_W  = 47;
   localparam int CSR_INDEX_W = 3;

   // Calibration fraction bits
   localparam int Q_SHIFT = 24;

   // Register window length and gain after reset
   localparam logic [WL_W-1:0] WINDOW_LENGTH_RESET = WL_W'(100);
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << Q_SHIFT;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_GAIN   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_OFFSET = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLTAGE_GAIN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLTAGE_OFFSET = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_TIME    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_LIMIT    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_DELAY    = 3'd7;

   // Input command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;       // add an accepted sample
      logic clear;      // zero time, charge and energy
      logic div_start;  // launch both window dividers
      logic mul;        // average times gain
      logic cal;        // round, offset, saturate
      logic pwr;        // power and charge increment
      logic elo;        // low half of energy product
      logic ehi;        // high half of energy product
      logic esum;       // combine and saturate energy increment
      logic commit;     // update accumulators and load the result
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic complete;   // this sample closes the window
      logic div_busy;   // dividers still iterating
   } status_type;

endpackage

`default_nettype wire

>>> src/window_average_energy_meter.sv
// ============================================================================
// window_average_energy_meter - windowed current/voltage averaging meter
// Averages ADC sample pairs, calibrates them and accumulates time, charge
// and energy, with an over-power trip timer.
// ============================================================================
// An item that does not close a window (a sample, or a clear command) is
// accepted in the idle state and the next item may follow right away. A sample
// that closes a window holds off the next item while the two restoring dividers
// produce one quotient bit per cycle across the SUM_W bits of the window sums,
// where SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) + 1, and then the calibration,
// power and energy multiply steps run. The finished result sits in an output
// register, so a stalled result only delays the next window close.
// ============================================================================
`default_nettype none

module window_average_energy_meter #(
   parameter int SAMPLE_BITS = wam_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = wam_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration
   input  wire logic                              csr_write_enable,
   input  wire logic [wam_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [wam_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // input items
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_command,
   input  wire logic signed [SAMPLE_BITS-1:0]     req_current_raw,
   input  wire logic signed [SAMPLE_BITS-1:0]     req_voltage_raw,
   input  wire logic [wam_pkg::MS_W-1:0]          req_now_ms,
   input  wire logic                              req_load_on,
   input  wire logic                              req_recording,
   // result items
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [wam_pkg::VALUE_W-1:0]     rsp_current_value,
   output logic signed [wam_pkg::VALUE_W-1:0]     rsp_voltage_value,
   output logic signed [wam_pkg::ACC_W-1:0]       rsp_charge_total,
   output logic signed [wam_pkg::ACC_W-1:0]       rsp_energy_total,
   output logic [wam_pkg::ELAPSED_W-1:0]          rsp_elapsed_us,
   output logic signed [SAMPLE_BITS-1:0]          rsp_current_average_raw,
   output logic signed [SAMPLE_BITS-1:0]          rsp_voltage_average_raw,
   output logic                                   rsp_power_trip
);

   import wam_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer
   wam_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // Arithmetic and state
   wam_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .current_raw         (req_current_raw),
      .voltage_raw         (req_voltage_raw),
      .now_ms              (req_now_ms),
      .load_on             (req_load_on),
      .recording           (req_recording),
      .cmd                 (cmd),
      .status              (status),
      .current_value       (rsp_current_value),
      .voltage_value       (rsp_voltage_value),
      .charge_total        (rsp_charge_total),
      .energy_total        (rsp_energy_total),
      .elapsed_us          (rsp_elapsed_us),
      .current_average_raw (rsp_current_average_raw),
      .voltage_average_raw (rsp_voltage_average_raw),
      .power_trip          (rsp_power_trip)
   );

endmodule

`default_nettype wire

>>> src/wam_divider.sv
// ============================================================================
// wam_divider - signed by unsigned restoring divider
// Truncates toward zero, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module wam_divider #(
   parameter int DIVIDEND_W = 35,
   parameter int DIVISOR_W  = 11,
   parameter int QUOT_W     = 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [DIVIDEND_W-1:0] dividend,
   input  wire logic        [DIVISOR_W-1:0]  divisor,
   output logic                              busy,
   output logic signed      [QUOT_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] q_ff, q_in;
   logic [DIVISOR_W-1:0]  r_ff, r_in;
   logic [DIVISOR_W-1:0]  d_ff, d_in;
   logic                  neg_ff, neg_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;
   logic [DIVIDEND_W-1:0] mag;
   logic [DIVIDEND_W-1:0] signed_q;

   // One restoring step
   always_comb begin
      trial = {r_ff, q_ff[DIVIDEND_W-1]};
      fits  = trial >= {1'b0, d_ff};
      diff  = trial - {1'b0, d_ff};
      mag   = dividend[DIVIDEND_W-1] ? (~dividend + DIVIDEND_W'(1)) : dividend;
   end

   // Load on start, iterate while busy
   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = mag;
         r_in    = '0;
         d_in    = divisor;
         neg_in  = dividend[DIVIDEND_W-1];
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in    = {q_ff[DIVIDEND_W-2:0], fits};
         r_in    = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   // Apply the dividend sign
   always_comb begin
      signed_q = neg_ff ? (~q_ff + DIVIDEND_W'(1)) : q_ff;
   end

   assign busy     = busy_ff;
   assign quotient = signed_q[QUOT_W-1:0];

endmodule

`default_nettype wire

>>> src/wam_datapath.sv
// ============================================================================
// wam_datapath - window sums, calibration and energy accumulation
// Holds the register file, the window state, the arithmetic stages and the
// result register.
// ============================================================================
`default_nettype none

module wam_datapath #(
   parameter int SAMPLE_BITS = wam_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = wam_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_write_enable,
   input  wire logic [wam_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [wam_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // sample fields
   input  wire logic signed [SAMPLE_BITS-1:0]       current_raw,
   input  wire logic signed [SAMPLE_BITS-1:0]       voltage_raw,
   input  wire logic [wam_pkg::MS_W-1:0]            now_ms,
   input  wire logic                                load_on,
   input  wire logic                                recording,
   // control link
   input  wire wam_pkg::cmd_type                    cmd,
   output wam_pkg::status_type                      status,
   // result fields
   output logic signed [wam_pkg::VALUE_W-1:0]       current_value,
   output logic signed [wam_pkg::VALUE_W-1:0]       voltage_value,
   output logic signed [wam_pkg::ACC_W-1:0]         charge_total,
   output logic signed [wam_pkg::ACC_W-1:0]         energy_total,
   output logic [wam_pkg::ELAPSED_W-1:0]            elapsed_us,
   output logic signed [SAMPLE_BITS-1:0]            current_average_raw,
   output logic signed [SAMPLE_BITS-1:0]            voltage_average_raw,
   output logic                                     power_trip
);

   import wam_pkg::*;

   localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
   localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W   = (COUNT_W > WL_W) ? COUNT_W : WL_W;
   localparam int PROD_W  = SAMPLE_BITS + GAIN_W;
   localparam int FL_W    = PROD_W - Q_SHIFT + 1;
   localparam int CAL_W   = ((FL_W > VALUE_W) ? FL_W : VALUE_W) + 1;
   localparam int PWR_W   = 2 * VALUE_W;
   localparam int CHG_W   = VALUE_W + WTIME_W + 1;
   localparam int ELO_W   = VALUE_W + WTIME_W;
   localparam int EHI_W   = VALUE_W + WTIME_W + 1;
   localparam int EFULL_W = EHI_W + VALUE_W;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [PROD_W:0] ROUND_BIAS = (PROD_W+1)'(1) << (Q_SHIFT - 1);

   // ------------------------------------------------------------------------
   // Register file
   // ------------------------------------------------------------------------
   logic [WL_W-1:0]           window_length_ff;
   logic signed [GAIN_W-1:0]  current_gain_ff, current_offset_ff;
   logic signed [GAIN_W-1:0]  voltage_gain_ff, voltage_offset_ff;
   logic [WTIME_W-1:0]        window_time_ff;
   logic [LIMIT_W-1:0]        power_limit_ff;
   logic [DELAY_W-1:0]        power_delay_ff;

   // Decode the register write
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff  <= WINDOW_LENGTH_RESET;
         current_gain_ff   <= GAIN_RESET;
         current_offset_ff <= '0;
         voltage_gain_ff   <= GAIN_RESET;
         voltage_offset_ff <= '0;
         window_time_ff    <= '0;
         power_limit_ff    <= '0;
         power_delay_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH:  window_length_ff  <= csr_wdata[WL_W-1:0];
            CSR_CURRENT_GAIN:   current_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_CURRENT_OFFSET: current_offset_ff <= csr_wdata[GAIN_W-1:0];
            CSR_VOLTAGE_GAIN:   voltage_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_VOLTAGE_OFFSET: voltage_offset_ff <= csr_wdata[GAIN_W-1:0];
            CSR_WINDOW_TIME:    window_time_ff    <= csr_wdata[WTIME_W-1:0];
            CSR_POWER_LIMIT:    power_limit_ff    <= csr_wdata[LIMIT_W-1:0];
            CSR_POWER_DELAY:    power_delay_ff    <= csr_wdata[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Window sums
   // ------------------------------------------------------------------------
   logic signed [SUM_W-1:0] current_sum_ff, current_sum_in;
   logic signed [SUM_W-1:0] voltage_sum_ff, voltage_sum_in;
   logic [COUNT_W-1:0]      sample_count_ff, sample_count_in;
   logic signed [SUM_W-1:0] cur_sum_next, volt_sum_next;
   logic [COUNT_W-1:0]      count_next;
   logic [CMP_W-1:0]        win_nz;
   logic                    complete;

   // Add the sample and test for the end of the window
   always_comb begin
      cur_sum_next  = current_sum_ff + SUM_W'(current_raw);
      volt_sum_next = voltage_sum_ff + SUM_W'(voltage_raw);
      count_next    = (sample_count_ff < COUNT_W'(MAX_WINDOW))
                      ? sample_count_ff + COUNT_W'(1) : sample_count_ff;
      win_nz        = (window_length_ff == '0) ? CMP_W'(1) : CMP_W'(window_length_ff);
      complete      = (CMP_W'(count_next) >= win_nz)
                      || (count_next == COUNT_W'(MAX_WINDOW));

      current_sum_in  = current_sum_ff;
      voltage_sum_in  = voltage_sum_ff;
      sample_count_in = sample_count_ff;
      if (cmd.load) begin
         current_sum_in  = complete ? '0 : cur_sum_next;
         voltage_sum_in  = complete ? '0 : volt_sum_next;
         sample_count_in = complete ? '0 : count_next;
      end
   end

   // ------------------------------------------------------------------------
   // Dividers
   // ------------------------------------------------------------------------
   logic                          busy_i, busy_v;
   logic signed [SAMPLE_BITS-1:0] ca, va;

   wam_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (COUNT_W),
      .QUOT_W     (SAMPLE_BITS)
   ) u_div_current (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cur_sum_next),
      .divisor  (count_next),
      .busy     (busy_i),
      .quotient (ca)
   );

   wam_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (COUNT_W),
      .QUOT_W     (SAMPLE_BITS)
   ) u_div_voltage (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (volt_sum_next),
      .divisor  (count_next),
      .busy     (busy_v),
      .quotient (va)
   );

   always_comb begin
      status.complete = complete;
      status.div_busy = busy_i | busy_v;
   end

   // ------------------------------------------------------------------------
   // Calibration
   // ------------------------------------------------------------------------
   logic signed [PROD_W-1:0]  prod_i_ff, prod_v_ff;
   logic signed [VALUE_W-1:0] iv_ff, vv_ff;
   logic signed [PROD_W:0]    round_i, round_v;
   logic signed [FL_W-1:0]    floor_i, floor_v;
   logic signed [CAL_W-1:0]   cal_i, cal_v;

   function automatic logic signed [VALUE_W-1:0] sat_value(
      input logic signed [CAL_W-1:0] v
   );
      logic signed [VALUE_W-1:0] r;
      if (v > CAL_W'(VAL_MAX)) begin
         r = VAL_MAX;
      end else if (v < CAL_W'(VAL_MIN)) begin
         r = VAL_MIN;
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction

   // Round half up, floor, add the offset
   always_comb begin
      round_i = $signed({prod_i_ff[PROD_W-1], prod_i_ff}) + $signed(ROUND_BIAS);
      round_v = $signed({prod_v_ff[PROD_W-1], prod_v_ff}) + $signed(ROUND_BIAS);
      floor_i = round_i[PROD_W:Q_SHIFT];
      floor_v = round_v[PROD_W:Q_SHIFT];
      cal_i   = CAL_W'(floor_i) + CAL_W'(current_offset_ff);
      cal_v   = CAL_W'(floor_v) + CAL_W'(voltage_offset_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_i_ff <= ca * current_gain_ff;
         prod_v_ff <= va * voltage_gain_ff;
      end
      if (cmd.cal) begin
         iv_ff <= sat_value(cal_i);
         vv_ff <= sat_value(cal_v);
      end
   end

   // ------------------------------------------------------------------------
   // Power, charge and energy increments
   // ------------------------------------------------------------------------
   logic signed [PWR_W-1:0]   power_ff;
   logic signed [CHG_W-1:0]   chg_inc_ff;
   logic [ELO_W-1:0]          elo_ff;
   logic signed [EHI_W-1:0]   ehi_ff;
   logic signed [ACC_W-1:0]   einc_ff;
   logic signed [WTIME_W:0]   wtime_s;
   logic signed [EFULL_W-1:0] efull;
   logic signed [ACC_W-1:0]   einc_in;

   // Combine the two energy partial products and saturate
   always_comb begin
      wtime_s = $signed({1'b0, window_time_ff});
      efull   = $signed({ehi_ff, {VALUE_W{1'b0}}}) + $signed(EFULL_W'(elo_ff));
      if (efull > EFULL_W'(ACC_MAX)) begin
         einc_in = ACC_MAX;
      end else if (efull < EFULL_W'(ACC_MIN)) begin
         einc_in = ACC_MIN;
      end else begin
         einc_in = efull[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pwr) begin
         power_ff   <= iv_ff * vv_ff;
         chg_inc_ff <= iv_ff * wtime_s;
      end
      if (cmd.elo) begin
         elo_ff <= power_ff[VALUE_W-1:0] * window_time_ff;
      end
      if (cmd.ehi) begin
         ehi_ff <= $signed(power_ff[PWR_W-1:VALUE_W]) * wtime_s;
      end
      if (cmd.esum) begin
         einc_ff <= einc_in;
      end
   end

   // ------------------------------------------------------------------------
   // Accumulators, over-power timer and result register
   // ------------------------------------------------------------------------
   logic signed [ACC_W-1:0] charge_ff, charge_in;
   logic signed [ACC_W-1:0] energy_ff, energy_in;
   logic [ELAPSED_W-1:0]    time_ff, time_in;
   logic                    op_active_ff, op_active_in;
   logic [MS_W-1:0]         op_start_ff, op_start_in;
   logic [MS_W-1:0]         now_ff;
   logic                    on_ff, rec_ff;
   logic signed [ACC_W:0]   chg_sum, nrg_sum;
   logic [ELAPSED_W:0]      time_sum;
   logic signed [ACC_W-1:0] charge_upd, energy_upd;
   logic [ELAPSED_W-1:0]    time_upd;
   logic                    over;
   logic                    trip;
   logic [MS_W-1:0]         held_ms;

   logic signed [VALUE_W-1:0]     current_value_ff, voltage_value_ff;
   logic signed [ACC_W-1:0]       charge_total_ff, energy_total_ff;
   logic [ELAPSED_W-1:0]          elapsed_ff;
   logic signed [SAMPLE_BITS-1:0] cur_avg_ff, volt_avg_ff;
   logic                          trip_ff;

   // Hold the sample's side fields for the end of the window
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff <= now_ms;
         on_ff  <= load_on;
         rec_ff <= recording;
      end
   end

   // Saturating updates and over-power check
   always_comb begin
      chg_sum  = {charge_ff[ACC_W-1], charge_ff} + (ACC_W+1)'(chg_inc_ff);
      nrg_sum  = {energy_ff[ACC_W-1], energy_ff} + {einc_ff[ACC_W-1], einc_ff};
      time_sum = {1'b0, time_ff} + (ELAPSED_W+1)'(window_time_ff);

      if (chg_sum[ACC_W] != chg_sum[ACC_W-1]) begin
         charge_upd = chg_sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         charge_upd = chg_sum[ACC_W-1:0];
      end
      if (nrg_sum[ACC_W] != nrg_sum[ACC_W-1]) begin
         energy_upd = nrg_sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         energy_upd = nrg_sum[ACC_W-1:0];
      end
      time_upd = time_sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : time_sum[ELAPSED_W-1:0];

      over    = on_ff && !power_ff[PWR_W-1]
                && (power_ff[PWR_W-2:0] > (PWR_W-1)'(power_limit_ff));
      held_ms = now_ff - op_start_ff;

      charge_in    = charge_ff;
      energy_in    = energy_ff;
      time_in      = time_ff;
      op_active_in = op_active_ff;
      op_start_in  = op_start_ff;
      trip         = 1'b0;

      if (cmd.clear) begin
         charge_in = '0;
         energy_in = '0;
         time_in   = '0;
      end else if (cmd.commit) begin
         if (on_ff && rec_ff) begin
            charge_in = charge_upd;
            energy_in = energy_upd;
            time_in   = time_upd;
         end
         if (over) begin
            if (!op_active_ff) begin
               op_start_in  = now_ff;
               op_active_in = 1'b1;
            end else begin
               trip = held_ms >= power_delay_ff;
            end
         end else begin
            op_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_sum_ff  <= '0;
         voltage_sum_ff  <= '0;
         sample_count_ff <= '0;
         charge_ff       <= '0;
         energy_ff       <= '0;
         time_ff         <= '0;
         op_active_ff    <= 1'b0;
         op_start_ff     <= '0;
      end else begin
         current_sum_ff  <= current_sum_in;
         voltage_sum_ff  <= voltage_sum_in;
         sample_count_ff <= sample_count_in;
         charge_ff       <= charge_in;
         energy_ff       <= energy_in;
         time_ff         <= time_in;
         op_active_ff    <= op_active_in;
         op_start_ff     <= op_start_in;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         current_value_ff <= iv_ff;
         voltage_value_ff <= vv_ff;
         charge_total_ff  <= charge_in;
         energy_total_ff  <= energy_in;
         elapsed_ff       <= time_in;
         cur_avg_ff       <= ca;
         volt_avg_ff      <= va;
         trip_ff          <= trip;
      end
   end

   assign current_value       = current_value_ff;
   assign voltage_value       = voltage_value_ff;
   assign charge_total        = charge_total_ff;
   assign energy_total        = energy_total_ff;
   assign elapsed_us          = elapsed_ff;
   assign current_average_raw = cur_avg_ff;
   assign voltage_average_raw = volt_avg_ff;
   assign power_trip          = trip_ff;

endmodule

`default_nettype wire

>>> src/wam_ctrl.sv
// ============================================================================
// wam_ctrl - sequencer for the window average energy meter
// Accepts items, steps the datapath through a window close and owns the
// result valid flag.
// ============================================================================
`default_nettype none

module wam_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_command,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire wam_pkg::status_type status,
   output wam_pkg::cmd_type         cmd
);

   import wam_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DIV  = 4'd1;
   localparam logic [3:0] ST_MUL  = 4'd2;
   localparam logic [3:0] ST_CAL  = 4'd3;
   localparam logic [3:0] ST_PWR  = 4'd4;
   localparam logic [3:0] ST_ELO  = 4'd5;
   localparam logic [3:0] ST_EHI  = 4'd6;
   localparam logic [3:0] ST_ESUM = 4'd7;
   localparam logic [3:0] ST_DONE = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   // Decode the state into datapath commands
   always_comb begin
      accept   = req_valid && (state_ff == ST_IDLE);
      out_free = !rsp_valid_ff || !rsp_stall;

      cmd           = '0;
      cmd.load      = accept && (req_command == CMD_SAMPLE);
      cmd.clear     = accept && (req_command == CMD_CLEAR);
      cmd.div_start = cmd.load && status.complete;
      state_in      = state_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.div_start) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_busy) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CAL;
         end
         ST_CAL: begin
            cmd.cal  = 1'b1;
            state_in = ST_PWR;
         end
         ST_PWR: begin
            cmd.pwr  = 1'b1;
            state_in = ST_ELO;
         end
         ST_ELO: begin
            cmd.elo  = 1'b1;
            state_in = ST_EHI;
         end
         ST_EHI: begin
            cmd.ehi  = 1'b1;
            state_in = ST_ESUM;
         end
         ST_ESUM: begin
            cmd.esum = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Set on commit, drop on transfer
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
